// File: design/frs_pkg.sv
`timescale 1ns / 1ps

package frs_pkg;

   localparam int unsigned TIME_WIDTH = 32;
   localparam int unsigned CFG_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FALL_TIME = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIFT_TIME = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FACING_UP = 2'd2;

   localparam logic [CFG_WIDTH-1:0] FALL_TIME_RESET = 16'd500;
   localparam logic [CFG_WIDTH-1:0] LIFT_TIME_RESET = 16'd1000;
   localparam logic signed [CFG_WIDTH-1:0] FACING_UP_RESET = 16'sd0;

   localparam logic signed [15:0] TILT_POS_LIMIT = 16'sd4096;
   localparam logic signed [15:0] TILT_NEG_LIMIT = -16'sd4096;

   localparam logic [1:0] BODY_KEYFRAME = 2'd1;

   localparam logic [2:0] KF_NONE = 3'd0;
   localparam logic [2:0] KF_SPREAD = 3'd1;
   localparam logic [2:0] KF_GETUP_FRONT = 3'd2;
   localparam logic [2:0] KF_GETUP_BACK = 3'd3;

   localparam logic [2:0] REQ_NONE = 3'd0;
   localparam logic [2:0] REQ_SPREAD = 3'd1;
   localparam logic [2:0] REQ_GETUP_FRONT = 3'd2;
   localparam logic [2:0] REQ_GETUP_BACK = 3'd3;
   localparam logic [2:0] REQ_CLEAR_BODY = 3'd4;

   localparam logic [1:0] STATUS_NONE = 2'd0;
   localparam logic [1:0] STATUS_LIFTED = 2'd1;
   localparam logic [1:0] STATUS_GETUP = 2'd2;

   localparam logic [1:0] ANN_NONE = 2'd0;
   localparam logic [1:0] ANN_LIFTED = 2'd1;
   localparam logic [1:0] ANN_BELLY = 2'd2;
   localparam logic [1:0] ANN_BACK = 2'd3;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_LIFTED = 2'd1,
      MODE_SPREAD = 2'd2,
      MODE_GETUP  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] tick_time_ms;
      logic signed [15:0]    tilt_x;
      logic signed [15:0]    tilt_y;
      logic                  on_ground;
      logic [1:0]            body_cmd_kind;
      logic [2:0]            keyframe_kind;
      logic                  penalized;
      logic                  hold_phase;
   } req_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [2:0] body_request;
      logic       stop_walk;
      logic       clear_head;
      logic [1:0] status_flag;
      logic [1:0] announce;
      logic       skipped;
   } rsp_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0]        fall_time_ms;
      logic [CFG_WIDTH-1:0]        lift_time_ms;
      logic signed [CFG_WIDTH-1:0] facing_up_angle;
   } cfg_type;

   typedef struct packed {
      mode_type              cur_mode;
      logic                  first_entry;
      logic [TIME_WIDTH-1:0] lift_stamp;
      logic [TIME_WIDTH-1:0] fall_stamp;
      logic                  front_side;
      logic                  keyframe_seen;
   } state_type;

endpackage

// File: design/frs_csr.sv
`timescale 1ns / 1ps

module frs_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [frs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [frs_pkg::CFG_WIDTH-1:0]        csr_data,
   output frs_pkg::cfg_type                     cfg
);
   import frs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FALL_TIME: cfg_in.fall_time_ms = csr_data;
            CSR_LIFT_TIME: cfg_in.lift_time_ms = csr_data;
            CSR_FACING_UP: cfg_in.facing_up_angle = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fall_time_ms <= FALL_TIME_RESET;
         cfg_ff.lift_time_ms <= LIFT_TIME_RESET;
         cfg_ff.facing_up_angle <= FACING_UP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/frs_step.sv
`timescale 1ns / 1ps

module frs_step (
   input  frs_pkg::req_type   req,
   input  frs_pkg::state_type st,
   input  frs_pkg::cfg_type   cfg,
   output frs_pkg::state_type st_next,
   output frs_pkg::rsp_type   rsp
);
   import frs_pkg::*;

   logic [TIME_WIDTH-1:0] now;
   logic [TIME_WIDTH-1:0] lift_age;
   logic [TIME_WIDTH-1:0] fall_age;
   logic                  lift_exp;
   logic                  fall_exp;
   logic                  fallen;
   logic                  kf_active;
   logic                  play_spread;
   logic                  play_getup;
   logic                  facing_front;
   logic [2:0]            want_kf;
   logic [2:0]            want_req;

   logic                  to_spread;
   logic                  to_normal;
   mode_type              mode_end;
   logic [2:0]            req_code;
   logic [1:0]            ann;
   logic [1:0]            status;
   state_type             nxt;

   assign now = req.tick_time_ms;
   assign lift_age = now - st.lift_stamp;
   assign fall_age = now - st.fall_stamp;
   assign lift_exp = lift_age > {{(TIME_WIDTH-CFG_WIDTH){1'b0}}, cfg.lift_time_ms};
   assign fall_exp = fall_age > {{(TIME_WIDTH-CFG_WIDTH){1'b0}}, cfg.fall_time_ms};

   assign fallen = (req.tilt_x < TILT_NEG_LIMIT) || (req.tilt_x > TILT_POS_LIMIT) ||
                   (req.tilt_y < TILT_NEG_LIMIT) || (req.tilt_y > TILT_POS_LIMIT);

   assign kf_active = (req.body_cmd_kind == BODY_KEYFRAME) && (req.keyframe_kind != KF_NONE);
   assign play_spread = (req.body_cmd_kind == BODY_KEYFRAME) &&
                        (req.keyframe_kind == KF_SPREAD);
   assign want_kf = st.front_side ? KF_GETUP_FRONT : KF_GETUP_BACK;
   assign want_req = st.front_side ? REQ_GETUP_FRONT : REQ_GETUP_BACK;
   assign play_getup = (req.body_cmd_kind == BODY_KEYFRAME) && (req.keyframe_kind == want_kf);
   assign facing_front = req.tilt_y > cfg.facing_up_angle;

   always_comb begin
      nxt = st;
      nxt.first_entry = 1'b0;
      mode_end = st.cur_mode;
      req_code = REQ_NONE;
      ann = ANN_NONE;
      to_spread = 1'b0;
      to_normal = 1'b0;

      unique case (st.cur_mode)
         MODE_NORMAL: begin
            if (st.first_entry) begin
               nxt.lift_stamp = now;
               nxt.fall_stamp = now;
            end else if (!(req.on_ground || kf_active) && lift_exp) begin
               ann = ANN_LIFTED;
               nxt.lift_stamp = now;
               if (!fallen) begin
                  nxt.fall_stamp = now;
                  mode_end = MODE_LIFTED;
               end else if (fall_exp) begin
                  to_spread = 1'b1;
               end else begin
                  mode_end = MODE_LIFTED;
               end
            end else begin
               if (req.on_ground || kf_active) begin
                  nxt.lift_stamp = now;
               end
               if (!fallen) begin
                  nxt.fall_stamp = now;
               end else if (fall_exp) begin
                  to_spread = 1'b1;
               end
            end
         end
         MODE_LIFTED: begin
            if (!req.on_ground) begin
               nxt.lift_stamp = now;
            end
            if (req.on_ground && lift_exp) begin
               to_normal = 1'b1;
            end else if (!fallen) begin
               nxt.fall_stamp = now;
            end else if (fall_exp) begin
               to_spread = 1'b1;
            end
         end
         MODE_SPREAD: begin
            if (st.keyframe_seen && !play_spread) begin
               mode_end = MODE_GETUP;
               nxt.keyframe_seen = 1'b0;
               nxt.front_side = facing_front;
               ann = facing_front ? ANN_BELLY : ANN_BACK;
               req_code = facing_front ? REQ_GETUP_FRONT : REQ_GETUP_BACK;
            end else begin
               nxt.keyframe_seen = st.keyframe_seen || play_spread;
               req_code = (st.keyframe_seen || play_spread) ? REQ_CLEAR_BODY : REQ_SPREAD;
            end
         end
         MODE_GETUP: begin
            if (st.keyframe_seen && !play_getup) begin
               to_normal = 1'b1;
            end else begin
               nxt.keyframe_seen = st.keyframe_seen || play_getup;
               req_code = (st.keyframe_seen || play_getup) ? REQ_CLEAR_BODY : want_req;
            end
         end
      endcase

      if (to_spread) begin
         if (req.hold_phase) begin
            to_normal = 1'b1;
         end else begin
            mode_end = MODE_SPREAD;
            nxt.keyframe_seen = 1'b0;
            req_code = REQ_SPREAD;
         end
      end

      if (to_normal) begin
         mode_end = MODE_NORMAL;
         nxt.lift_stamp = now;
         nxt.fall_stamp = now;
      end

      nxt.cur_mode = mode_end;

      unique case (mode_end)
         MODE_NORMAL: status = STATUS_NONE;
         MODE_LIFTED: status = STATUS_LIFTED;
         MODE_SPREAD, MODE_GETUP: status = STATUS_GETUP;
      endcase

      if (req.penalized) begin
         st_next = st;
         rsp.mode = 2'(st.cur_mode);
         rsp.body_request = REQ_NONE;
         rsp.stop_walk = 1'b0;
         rsp.clear_head = 1'b0;
         rsp.status_flag = STATUS_NONE;
         rsp.announce = ANN_NONE;
         rsp.skipped = 1'b1;
      end else begin
         st_next = nxt;
         rsp.mode = 2'(mode_end);
         rsp.body_request = req_code;
         rsp.stop_walk = (mode_end == MODE_LIFTED);
         rsp.clear_head = (mode_end != MODE_NORMAL);
         rsp.status_flag = status;
         rsp.announce = ann;
         rsp.skipped = 1'b0;
      end
   end

endmodule

// File: design/fall_recovery_sequencer.sv
`timescale 1ns / 1ps
// An accepted word is held in the input register and moves into the result register once
// the result register is free or being read, so a stall on the result side holds it there.
// The block takes one word per cycle while the result side does not stall, set by the single
// pass from the input register to the result register, which also updates the mode state.
// Reset clears both valid registers, returns the machine to normal mode with entry pending,
// and restores the configuration registers to their default values.

module fall_recovery_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  frs_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output frs_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write,
   input  logic [frs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [frs_pkg::CFG_WIDTH-1:0]        csr_data
);
   import frs_pkg::*;

   cfg_type   cfg;

   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_data_ff;
   req_type   in_data_in;
   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_data_in;

   state_type step_state;
   rsp_type   step_rsp;
   logic      advance;
   logic      take_in;

   frs_csr u_frs_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   frs_step u_frs_step (
      .req     (in_data_ff),
      .st      (state_ff),
      .cfg     (cfg),
      .st_next (step_state),
      .rsp     (step_rsp)
   );

   assign advance = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take_in = req_valid && !req_stall;

   always_comb begin
      in_valid_in = take_in || (in_valid_ff && !advance);
      in_data_in = take_in ? req_data : in_data_ff;
      state_in = advance ? step_state : state_ff;
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
      rsp_data_in = advance ? step_rsp : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff.cur_mode <= MODE_NORMAL;
         state_ff.first_entry <= 1'b1;
         state_ff.lift_stamp <= '0;
         state_ff.fall_stamp <= '0;
         state_ff.front_side <= 1'b1;
         state_ff.keyframe_seen <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// File: design/frs_checker.sv
`timescale 1ns / 1ps

module frs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input frs_pkg::rsp_type rsp_data
);
   import frs_pkg::*;

   logic [1:0] last_mode_ff;
   logic [1:0] last_mode_in;
   logic       rsp_take;

   assign rsp_take = rsp_valid && !rsp_stall;
   assign last_mode_in = rsp_take ? rsp_data.mode : last_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_mode_ff <= 2'(MODE_NORMAL);
      end else begin
         last_mode_ff <= last_mode_in;
      end
   end

   a_reset_clears_output: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while result side can move");

   a_skipped_keeps_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_data.skipped |-> rsp_data.mode == last_mode_ff)
      else $error("skipped word changed the mode");

   a_getup_exit: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_data.skipped && last_mode_ff == MODE_GETUP |->
         rsp_data.mode == MODE_GETUP || rsp_data.mode == MODE_NORMAL)
      else $error("get up left to a mode other than normal");

endmodule

bind fall_recovery_sequencer frs_checker u_frs_checker (.*);

// File: test/fall_recovery_sequencer_tb.sv
`timescale 1ns / 1ps

module fall_recovery_sequencer_tb;
   import frs_pkg::*;

   localparam logic [1:0] BODY_NONE = 2'd0;
   localparam logic [1:0] BODY_OTHER = 2'd2;
   localparam logic [2:0] KF_OTHER = 3'd4;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PRINT_LIMIT = 100;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   req_type                    req_data;
   logic                       rsp_valid;
   logic                       rsp_stall;
   rsp_type                    rsp_data;
   logic                       csr_write;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CFG_WIDTH-1:0]       csr_data;

   mode_type           mdl_mode;
   logic               mdl_entry;
   logic [31:0]        mdl_lift_ts;
   logic [31:0]        mdl_fall_ts;
   logic               mdl_front;
   logic               mdl_seen;
   logic [15:0]        cfg_fall;
   logic [15:0]        cfg_lift;
   logic signed [15:0] cfg_facing;

   rsp_type     pending_rsp_q[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          req_gap_max = 12;
   int          rsp_gap_max = 12;
   logic [31:0] now_ms = 32'd0;
   int          plan = 0;

   fall_recovery_sequencer DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < PRINT_LIMIT)
         $display("mismatch in %s: got %0d, expected %0d, cycle %0d", what, got, want,
                  cycle_count);
      error_count++;
   endtask

   task automatic reset_recovery_state;
      mdl_mode = MODE_NORMAL;
      mdl_entry = 1'b1;
      mdl_lift_ts = '0;
      mdl_fall_ts = '0;
      mdl_front = 1'b1;
      mdl_seen = 1'b0;
      cfg_fall = FALL_TIME_RESET;
      cfg_lift = LIFT_TIME_RESET;
      cfg_facing = FACING_UP_RESET;
   endtask

   function automatic rsp_type advance_recovery(input req_type w);
      rsp_type            r;
      logic signed [15:0] tx;
      logic signed [15:0] ty;
      logic [31:0]        now;
      logic               fallen;
      logic               kf_busy;
      logic               fresh;
      logic               getup;
      logic               playing;
      logic               done;
      mode_type           nxt;
      logic [2:0]         want_kf;
      logic [2:0]         want_req;
      r = '0;
      if (w.penalized) begin
         r.mode = mdl_mode;
         r.skipped = 1'b1;
         return r;
      end
      tx = w.tilt_x;
      ty = w.tilt_y;
      now = w.tick_time_ms;
      fallen = (tx < TILT_NEG_LIMIT) || (tx > TILT_POS_LIMIT) ||
               (ty < TILT_NEG_LIMIT) || (ty > TILT_POS_LIMIT);
      kf_busy = (w.keyframe_kind != KF_NONE) && (w.body_cmd_kind == BODY_KEYFRAME);
      done = 1'b0;
      for (int g = 0; g < 8 && !done; g++) begin
         fresh = mdl_entry;
         nxt = mdl_mode;
         case (mdl_mode)
            MODE_NORMAL: begin
               if (fresh) begin
                  mdl_lift_ts = now;
                  mdl_fall_ts = now;
               end
               if (w.on_ground || kf_busy) mdl_lift_ts = now;
               else if (32'(now - mdl_lift_ts) > 32'(cfg_lift)) nxt = MODE_LIFTED;
               if (nxt == mdl_mode) begin
                  if (!fallen) mdl_fall_ts = now;
                  else if (32'(now - mdl_fall_ts) > 32'(cfg_fall)) nxt = MODE_SPREAD;
               end
               if (nxt == mdl_mode) done = 1'b1;
            end
            MODE_LIFTED: begin
               if (fresh) begin
                  r.announce = ANN_LIFTED;
                  mdl_lift_ts = now;
               end
               if (!w.on_ground) mdl_lift_ts = now;
               else if (32'(now - mdl_lift_ts) > 32'(cfg_lift)) nxt = MODE_NORMAL;
               if (nxt == mdl_mode) begin
                  if (!fallen) mdl_fall_ts = now;
                  else if (32'(now - mdl_fall_ts) > 32'(cfg_fall)) nxt = MODE_SPREAD;
               end
               if (nxt == mdl_mode) begin
                  r.status_flag = STATUS_LIFTED;
                  r.stop_walk = 1'b1;
                  r.clear_head = 1'b1;
                  done = 1'b1;
               end
            end
            default: begin
               getup = (mdl_mode == MODE_GETUP);
               if (fresh) begin
                  if (!getup && w.hold_phase) nxt = MODE_NORMAL;
                  else begin
                     mdl_seen = 1'b0;
                     if (getup) begin
                        mdl_front = (ty > cfg_facing);
                        r.announce = mdl_front ? ANN_BELLY : ANN_BACK;
                     end
                  end
               end
               if (nxt == mdl_mode) begin
                  want_kf = !getup ? KF_SPREAD : (mdl_front ? KF_GETUP_FRONT : KF_GETUP_BACK);
                  want_req = !getup ? REQ_SPREAD :
                             (mdl_front ? REQ_GETUP_FRONT : REQ_GETUP_BACK);
                  playing = (w.body_cmd_kind == BODY_KEYFRAME) && (w.keyframe_kind == want_kf);
                  if (playing && !fresh) mdl_seen = 1'b1;
                  if (mdl_seen && !playing) nxt = getup ? MODE_NORMAL : MODE_GETUP;
                  else begin
                     r.body_request = mdl_seen ? REQ_CLEAR_BODY : want_req;
                     r.clear_head = 1'b1;
                     r.status_flag = STATUS_GETUP;
                     done = 1'b1;
                  end
               end
            end
         endcase
         if (!done) begin
            mdl_mode = nxt;
            mdl_entry = 1'b1;
         end
      end
      mdl_entry = 1'b0;
      r.mode = mdl_mode;
      return r;
   endfunction

   // The valid line is left high after a handshake so that a word with no gap follows at once.
   task automatic send_word(input req_type w);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_rsp_q.push_back(advance_recovery(w));
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] fall, input logic [15:0] lift,
                             input logic [15:0] facing);
      csr_write <= 1'b1;
      csr_index <= CSR_FALL_TIME;
      csr_data <= fall;
      @(posedge clock);
      csr_index <= CSR_LIFT_TIME;
      csr_data <= lift;
      @(posedge clock);
      csr_index <= CSR_FACING_UP;
      csr_data <= facing;
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_fall = fall;
      cfg_lift = lift;
      cfg_facing = facing;
   endtask

   task automatic drive_tick(input logic [31:0] t, input logic signed [15:0] tx,
                             input logic signed [15:0] ty, input logic gnd,
                             input logic [1:0] bk, input logic [2:0] kk,
                             input logic pen, input logic hold);
      req_type w;
      w.tick_time_ms = t;
      w.tilt_x = tx;
      w.tilt_y = ty;
      w.on_ground = gnd;
      w.body_cmd_kind = bk;
      w.keyframe_kind = kk;
      w.penalized = pen;
      w.hold_phase = hold;
      now_ms = t;
      send_word(w);
   endtask

   // Most ticks follow a calm, airborne or tipping pattern; in spread or get up mode most also
   // play the keyframe the sequencer currently asks for, so that whole recoveries run through.
   task automatic random_ticks(input int count, input int step_max);
      req_type            w;
      logic signed [15:0] big;
      repeat (count) begin
         if ($urandom_range(0, 15) == 0) plan = $urandom_range(0, 2);
         case ($urandom_range(0, 19))
            0: now_ms = now_ms + $urandom;
            1: now_ms = now_ms;
            default: now_ms = now_ms + $urandom_range(0, step_max);
         endcase
         w.tick_time_ms = now_ms;
         w.tilt_x = 16'(int'($urandom_range(0, 8192)) - 4096);
         w.tilt_y = 16'(int'($urandom_range(0, 8192)) - 4096);
         if (plan == 2) begin
            big = 16'($urandom_range(4097, 32768));
            if ($urandom_range(0, 1)) big = -big;
            if ($urandom_range(0, 1)) w.tilt_x = big;
            else w.tilt_y = big;
         end
         if ($urandom_range(0, 9) == 0) w.tilt_x = 16'($urandom);
         if ($urandom_range(0, 9) == 0) w.tilt_y = 16'($urandom);
         w.on_ground = (plan == 1) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 9) != 0);
         if ((mdl_mode == MODE_SPREAD || mdl_mode == MODE_GETUP) &&
             $urandom_range(0, 9) < 6) begin
            w.body_cmd_kind = BODY_KEYFRAME;
            w.keyframe_kind = (mdl_mode == MODE_SPREAD) ? KF_SPREAD :
                              (mdl_front ? KF_GETUP_FRONT : KF_GETUP_BACK);
         end else if ($urandom_range(0, 1)) begin
            w.body_cmd_kind = BODY_NONE;
            w.keyframe_kind = KF_NONE;
         end else begin
            w.body_cmd_kind = 2'($urandom_range(0, 3));
            w.keyframe_kind = 3'($urandom_range(0, 7));
         end
         w.penalized = ($urandom_range(0, 19) == 0);
         w.hold_phase = ($urandom_range(0, 7) == 0);
         send_word(w);
      end
   endtask

   task automatic run_random_phase(input logic [15:0] fall, input logic [15:0] lift,
                                   input logic [15:0] facing, input int req_gap,
                                   input int rsp_gap, input int step_max, input int count);
      drain_results();
      set_config(fall, lift, facing);
      req_gap_max = req_gap;
      rsp_gap_max = rsp_gap;
      random_ticks(count, step_max);
   endtask

   task automatic test_penalized_tick;
      drive_tick(32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000, 1'b0, 2'd3, 3'd7, 1'b1, 1'b1);
   endtask

   task automatic test_lift_detection;
      drive_tick(100, 0, 0, 1'b1, BODY_NONE, KF_NONE, 1'b0, 1'b0);
      drive_tick(200, 4096, -4096, 1'b0, BODY_NONE, KF_NONE, 1'b0, 1'b0);
      drive_tick(1201, -4096, 4096, 1'b0, BODY_NONE, KF_NONE, 1'b0, 1'b0);
      drive_tick(1300, 0, 0, 1'b1, BODY_NONE, KF_NONE, 1'b0, 1'b0);
      drive_tick(2400, 0, 0, 1'b1, BODY_NONE, KF_NONE, 1'b0, 1'b0);
      drive_tick(2500, 0, 0, 1'b0, BODY_KEYFRAME, KF_OTHER, 1'b0, 1'b0);
      drive_tick(4000, 0, 0, 1'b0, BODY_KEYFRAME, KF_OTHER, 1'b0, 1'b0);
   endtask

   task automatic test_fall_recovery;
      drive_tick(4100, 0, 4097, 1'b1, BODY_NONE, KF_NONE, 1'b0, 1'b0);
      drive_tick(4700, 0, 4097, 1'b1, BODY_NONE, KF_NONE, 1'b0, 1'b0);
      drive_tick(4800, 0, -5000, 1'b1, BODY_KEYFRAME, KF_SPREAD, 1'b0, 1'b0);
      drive_tick(4900, 0, -5000, 1'b1, BODY_NONE, KF_NONE, 1'b0, 1'b0);
      drive_tick(5000, 0, -5000, 1'b1, BODY_KEYFRAME, KF_GETUP_BACK, 1'b0, 1'b0);
      drive_tick(5100, 0, -5000, 1'b1, BODY_OTHER, KF_NONE, 1'b0, 1'b0);
   endtask

   task automatic test_held_getup;
      drive_tick(5200, 16'sh8000, 0, 1'b1, BODY_NONE, KF_NONE, 1'b0, 1'b0);
      drive_tick(5700, 16'sh8000, 4097, 1'b1, BODY_NONE, KF_NONE, 1'b0, 1'b1);
      drive_tick(6300, 16'sh7FFF, 8000, 1'b1, BODY_NONE, KF_NONE, 1'b0, 1'b0);
      drive_tick(6400, 16'sh7FFF, 8000, 1'b1, BODY_KEYFRAME, KF_SPREAD, 1'b0, 1'b0);
      drive_tick(6500, 16'sh7FFF, 8000, 1'b1, BODY_NONE, KF_NONE, 1'b0, 1'b0);
      drive_tick(6600, 16'sh7FFF, 8000, 1'b1, BODY_KEYFRAME, KF_GETUP_FRONT, 1'b0, 1'b0);
      drive_tick(6700, 0, 0, 1'b1, BODY_NONE, KF_NONE, 1'b0, 1'b0);
   endtask

   task automatic test_time_wrap;
      drive_tick(32'hFFFF_FF00, 0, 0, 1'b1, BODY_NONE, KF_NONE, 1'b0, 1'b0);
      drive_tick(32'h0000_0100, 0, 0, 1'b0, BODY_NONE, KF_NONE, 1'b0, 1'b0);
      drive_tick(32'h0000_0300, 0, 0, 1'b0, BODY_NONE, KF_NONE, 1'b0, 1'b0);
   endtask

   task automatic test_config_extremes;
      run_random_phase(16'd0, 16'd0, 16'h8000, 0, 0, 3, 150);
      run_random_phase(16'hFFFF, 16'hFFFF, 16'h7FFF, 12, 0, 20000, 150);
   endtask

   task automatic test_random_operation;
      run_random_phase(FALL_TIME_RESET, LIFT_TIME_RESET, FACING_UP_RESET, 12, 12, 300, 150);
      run_random_phase(16'd200, 16'd300, 16'($urandom), 0, 12, 150, 150);
      run_random_phase(16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                       16'($urandom_range(0, 8192) - 4096), 3, 3, 150, 150);
      run_random_phase(16'd100, 16'd150, 16'hF800, 12, 12, 80, 150);
   endtask

   initial begin
      for (;;) begin
         int stall_cycles;
         stall_cycles = $urandom_range(0, rsp_gap_max);
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("unexpected word", int'(rsp_data), 0);
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_data.mode !== want.mode)
               report_mismatch("mode", int'(rsp_data.mode), int'(want.mode));
            if (rsp_data.body_request !== want.body_request)
               report_mismatch("body_request", int'(rsp_data.body_request),
                               int'(want.body_request));
            if (rsp_data.stop_walk !== want.stop_walk)
               report_mismatch("stop_walk", int'(rsp_data.stop_walk), int'(want.stop_walk));
            if (rsp_data.clear_head !== want.clear_head)
               report_mismatch("clear_head", int'(rsp_data.clear_head),
                               int'(want.clear_head));
            if (rsp_data.status_flag !== want.status_flag)
               report_mismatch("status_flag", int'(rsp_data.status_flag),
                               int'(want.status_flag));
            if (rsp_data.announce !== want.announce)
               report_mismatch("announce", int'(rsp_data.announce), int'(want.announce));
            if (rsp_data.skipped !== want.skipped)
               report_mismatch("skipped", int'(rsp_data.skipped), int'(want.skipped));
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_FALL_TIME;
      csr_data <= '0;
      reset_recovery_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_penalized_tick();
      test_lift_detection();
      test_fall_recovery();
      test_held_getup();
      test_time_wrap();
      test_config_extremes();
      test_random_operation();
      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: fall_recovery_sequencer.f
design/frs_pkg.sv
design/frs_csr.sv
design/frs_step.sv
design/fall_recovery_sequencer.sv
design/frs_checker.sv
test/fall_recovery_sequencer_tb.sv
